// File: hw/rtl/canonical_huffman_table_builder_top_macros.svh
// Assertion macros for the canonical Huffman table builder.
// Included by canonical_huffman_table_builder_top; needs no other file.
`ifndef CANONICAL_HUFFMAN_TABLE_BUILDER_TOP_MACROS_SVH
`define CANONICAL_HUFFMAN_TABLE_BUILDER_TOP_MACROS_SVH

// same-cycle implication
`define CHTB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chtb assertion failed");

// next-cycle implication
`define CHTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chtb assertion failed");

`endif

// File: hw/rtl/chtb_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the canonical Huffman table builder. No dependencies.
package chtb_pkg;

   localparam int MAX_SYMBOLS_DEF     = 256;
   localparam int MAX_CODE_LENGTH_DEF = 16;

   localparam int ACTION_W = 2;
   localparam int LIDX_W   = 5;
   localparam int COUNT_W  = 8;
   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 16;
   localparam int LEN_W    = 5;
   localparam int STATUS_W = 2;
   localparam int WALK_W   = CODE_W + 1;

   localparam logic [ACTION_W-1:0] ACT_COUNT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SYMBOL = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EXTRA_SYM  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_LATE_COUNT = 2'd2;

   typedef struct packed {
      logic capture;
      logic do_count;
      logic do_clear;
      logic sym_start;
      logic walk_step;
      logic sym_finish;
      logic look_read;
      logic look_emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                walk_stop;
   } dp_status_type;

endpackage

// File: hw/rtl/canonical_huffman_table_builder_top.sv
// Top level of the canonical Huffman table builder: sequencer plus datapath.
// Depends on chtb_pkg, chtb_ctrl, chtb_datapath and the assertion macro header.
//
//   channel   direction  handshake          payload
//   request   in         start, busy        req_action, req_length_index,
//                                           req_length_count, req_symbol
//   response  out        rsp_strobe         rsp_code_bits, rsp_code_length, rsp_status
//
// Count and clear items execute in EXEC after acceptance, then strobe a registered result.
// Lookup items add a LOOK state after EXEC, set by the registered read of the symbol memory.
// Symbol items add WALK states after EXEC, skipping each empty length (up to
// MAX_CODE_LENGTH - 1), one length step per cycle through the count table.
// A new item is taken in the cycle its predecessor's result is strobed.
// Reset clears the count table and symbol valid bits at once; no sweep.
// The receiver cannot stall; each result is valid for one cycle only.

`include "canonical_huffman_table_builder_top_macros.svh"

module canonical_huffman_table_builder_top #(
   parameter int MAX_SYMBOLS     = chtb_pkg::MAX_SYMBOLS_DEF,
   parameter int MAX_CODE_LENGTH = chtb_pkg::MAX_CODE_LENGTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [chtb_pkg::ACTION_W-1:0]   req_action,
   input  logic [chtb_pkg::LIDX_W-1:0]     req_length_index,
   input  logic [chtb_pkg::COUNT_W-1:0]    req_length_count,
   input  logic [chtb_pkg::SYMBOL_W-1:0]   req_symbol,
   output logic                            rsp_strobe,
   output logic [chtb_pkg::CODE_W-1:0]     rsp_code_bits,
   output logic [chtb_pkg::LEN_W-1:0]      rsp_code_length,
   output logic [chtb_pkg::STATUS_W-1:0]   rsp_status
);

   chtb_pkg::ctl_cmd_type   cmd;
   chtb_pkg::dp_status_type stat;

   logic rsp_flagged;
   logic rsp_no_code;

   chtb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   chtb_datapath #(
      .MAX_SYMBOLS     (MAX_SYMBOLS),
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_length_index (req_length_index),
      .req_length_count (req_length_count),
      .req_symbol       (req_symbol),
      .rsp_code_bits    (rsp_code_bits),
      .rsp_code_length  (rsp_code_length),
      .rsp_status       (rsp_status)
   );

   assign rsp_flagged = rsp_strobe && (rsp_status != chtb_pkg::ST_OK);
   assign rsp_no_code = (rsp_code_length == '0) && (rsp_code_bits == '0);

   `CHTB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `CHTB_ASSERT_IMPLY(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))
   `CHTB_ASSERT_IMPLY(a_flag_no_code, clock, reset, rsp_flagged, rsp_no_code)
   `CHTB_ASSERT_IMPLY(a_empty_zero_bits, clock, reset, rsp_strobe && (rsp_code_length == '0), rsp_code_bits == '0)

endmodule

// File: hw/rtl/chtb_ctrl.sv
// Sequencer for the canonical Huffman table builder.
// Depends on chtb_pkg for codes and the command/status types.
module chtb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   output chtb_pkg::ctl_cmd_type  cmd,
   input  chtb_pkg::dp_status_type stat
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_LOOK = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.action)
               chtb_pkg::ACT_COUNT: begin
                  cmd.do_count = 1'b1;
                  strobe_in    = 1'b1;
                  state_in     = S_IDLE;
               end
               chtb_pkg::ACT_SYMBOL: begin
                  cmd.sym_start = 1'b1;
                  state_in      = S_WALK;
               end
               chtb_pkg::ACT_LOOKUP: begin
                  cmd.look_read = 1'b1;
                  state_in      = S_LOOK;
               end
               default: begin
                  cmd.do_clear = 1'b1;
                  strobe_in    = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_WALK: begin
            if (stat.walk_stop) begin
               cmd.sym_finish = 1'b1;
               strobe_in      = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_LOOK: begin
            cmd.look_emit = 1'b1;
            strobe_in     = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// File: hw/rtl/chtb_datapath.sv
// Datapath of the canonical Huffman table builder: count table, code walk,
// symbol code memory with valid bits, result registers. Depends on chtb_pkg.
module chtb_datapath #(
   parameter int MAX_SYMBOLS     = chtb_pkg::MAX_SYMBOLS_DEF,
   parameter int MAX_CODE_LENGTH = chtb_pkg::MAX_CODE_LENGTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  chtb_pkg::ctl_cmd_type           cmd,
   output chtb_pkg::dp_status_type         stat,
   input  logic [chtb_pkg::ACTION_W-1:0]   req_action,
   input  logic [chtb_pkg::LIDX_W-1:0]     req_length_index,
   input  logic [chtb_pkg::COUNT_W-1:0]    req_length_count,
   input  logic [chtb_pkg::SYMBOL_W-1:0]   req_symbol,
   output logic [chtb_pkg::CODE_W-1:0]     rsp_code_bits,
   output logic [chtb_pkg::LEN_W-1:0]      rsp_code_length,
   output logic [chtb_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int SYM_IDX_W = $clog2(MAX_SYMBOLS);
   localparam int CNT_IDX_W = $clog2(MAX_CODE_LENGTH);
   localparam int ENTRY_W   = chtb_pkg::LEN_W + chtb_pkg::CODE_W;
   localparam logic [chtb_pkg::SYMBOL_W:0] SYM_LIMIT = (chtb_pkg::SYMBOL_W + 1)'(MAX_SYMBOLS);
   localparam logic [chtb_pkg::LEN_W-1:0]  LEN_LIMIT = chtb_pkg::LEN_W'(MAX_CODE_LENGTH);

   logic [chtb_pkg::ACTION_W-1:0] action_ff;
   logic [chtb_pkg::LIDX_W-1:0]   lidx_ff;
   logic [chtb_pkg::COUNT_W-1:0]  lcnt_ff;
   logic [chtb_pkg::SYMBOL_W-1:0] sym_ff;

   logic [chtb_pkg::COUNT_W-1:0]  counts_ff [MAX_CODE_LENGTH];
   logic [MAX_SYMBOLS-1:0]        valid_ff;
   logic [ENTRY_W-1:0]            entry_mem [MAX_SYMBOLS];
   logic [ENTRY_W-1:0]            rd_data_ff;
   logic                          hit_ff;

   logic                          started_ff, started_in;
   logic [chtb_pkg::LEN_W-1:0]    cur_ff, cur_in;
   logic [chtb_pkg::WALK_W-1:0]   next_code_ff, next_code_in;
   logic [chtb_pkg::COUNT_W-1:0]  left_ff, left_in;

   logic [chtb_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [chtb_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [chtb_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          res_load;

   logic                          lidx_ok;
   logic [chtb_pkg::LIDX_W-1:0]   lidx_m1;
   logic                          sym_ok;
   logic [SYM_IDX_W-1:0]          sym_idx;
   logic [chtb_pkg::WALK_W-1:0]   code_mask;
   logic [chtb_pkg::WALK_W-1:0]   masked_code;
   logic                          have_code;
   logic                          count_we;
   logic                          mem_we;

   assign lidx_ok     = (lidx_ff != '0) && (lidx_ff <= LEN_LIMIT);
   assign lidx_m1     = lidx_ff - chtb_pkg::LIDX_W'(1);
   assign sym_ok      = ({1'b0, sym_ff} < SYM_LIMIT);
   assign sym_idx     = sym_ff[SYM_IDX_W-1:0];
   assign code_mask   = (chtb_pkg::WALK_W'(1) << cur_ff) - chtb_pkg::WALK_W'(1);
   assign masked_code = next_code_ff & code_mask;
   assign have_code   = (left_ff != '0);
   assign count_we    = cmd.do_count && !started_ff && lidx_ok;
   assign mem_we      = cmd.sym_finish && have_code && sym_ok;

   assign stat.action    = action_ff;
   assign stat.walk_stop = have_code || (cur_ff == LEN_LIMIT);

   always_comb begin
      started_in   = started_ff;
      cur_in       = cur_ff;
      next_code_in = next_code_ff;
      left_in      = left_ff;
      if (cmd.do_clear) begin
         started_in   = 1'b0;
         cur_in       = chtb_pkg::LEN_W'(1);
         next_code_in = '0;
         left_in      = '0;
      end
      if (cmd.sym_start && !started_ff) begin
         started_in   = 1'b1;
         cur_in       = chtb_pkg::LEN_W'(1);
         next_code_in = '0;
         left_in      = counts_ff[0];
      end
      if (cmd.walk_step) begin
         next_code_in = {next_code_ff[chtb_pkg::WALK_W-2:0], 1'b0};
         cur_in       = cur_ff + chtb_pkg::LEN_W'(1);
         left_in      = counts_ff[cur_ff[CNT_IDX_W-1:0]];
      end
      if (cmd.sym_finish && have_code) begin
         next_code_in = next_code_ff + chtb_pkg::WALK_W'(1);
         left_in      = left_ff - chtb_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      res_load  = cmd.do_count || cmd.do_clear || cmd.sym_finish || cmd.look_emit;
      code_in   = '0;
      len_in    = '0;
      status_in = chtb_pkg::ST_OK;
      if (cmd.do_count && started_ff) begin
         status_in = chtb_pkg::ST_LATE_COUNT;
      end
      if (cmd.sym_finish) begin
         if (have_code) begin
            code_in = masked_code[chtb_pkg::CODE_W-1:0];
            len_in  = cur_ff;
         end else begin
            status_in = chtb_pkg::ST_EXTRA_SYM;
         end
      end
      if (cmd.look_emit && hit_ff) begin
         code_in = rd_data_ff[chtb_pkg::CODE_W-1:0];
         len_in  = rd_data_ff[ENTRY_W-1:chtb_pkg::CODE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         cur_ff       <= chtb_pkg::LEN_W'(1);
         next_code_ff <= '0;
         left_ff      <= '0;
         valid_ff     <= '0;
         for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         started_ff   <= started_in;
         cur_ff       <= cur_in;
         next_code_ff <= next_code_in;
         left_ff      <= left_in;
         if (cmd.do_clear) begin
            valid_ff <= '0;
            for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
               counts_ff[i] <= '0;
            end
         end else begin
            if (count_we) begin
               counts_ff[lidx_m1[CNT_IDX_W-1:0]] <= lcnt_ff;
            end
            if (mem_we) begin
               valid_ff[sym_idx] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[sym_idx] <= {cur_ff, masked_code[chtb_pkg::CODE_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.look_read) begin
         rd_data_ff <= entry_mem[sym_idx];
         hit_ff     <= sym_ok && valid_ff[sym_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         lidx_ff   <= req_length_index;
         lcnt_ff   <= req_length_count;
         sym_ff    <= req_symbol;
      end
      if (res_load) begin
         code_ff   <= code_in;
         len_ff    <= len_in;
         status_ff <= status_in;
      end
   end

   assign rsp_code_bits   = code_ff;
   assign rsp_code_length = len_ff;
   assign rsp_status      = status_ff;

endmodule

// File: bench/canonical_huffman_table_builder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for canonical_huffman_table_builder_top: directed and random item
// streams with a built-in predictor of the canonical code walk. Needs only chtb_pkg and the RTL.
module canonical_huffman_table_builder_top_tb;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1350;

   typedef struct {
      logic [chtb_pkg::ACTION_W-1:0] action;
      logic [chtb_pkg::LIDX_W-1:0]   length_index;
      logic [chtb_pkg::COUNT_W-1:0]  length_count;
      logic [chtb_pkg::SYMBOL_W-1:0] symbol;
      bit                            drain_first;
   } table_item_type;

   typedef struct packed {
      logic [chtb_pkg::CODE_W-1:0]   code_bits;
      logic [chtb_pkg::LEN_W-1:0]    code_length;
      logic [chtb_pkg::STATUS_W-1:0] status;
   } code_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [chtb_pkg::ACTION_W-1:0] req_action = '0;
   logic [chtb_pkg::LIDX_W-1:0]   req_length_index = '0;
   logic [chtb_pkg::COUNT_W-1:0]  req_length_count = '0;
   logic [chtb_pkg::SYMBOL_W-1:0] req_symbol = '0;
   logic                          rsp_strobe;
   logic [chtb_pkg::CODE_W-1:0]   rsp_code_bits;
   logic [chtb_pkg::LEN_W-1:0]    rsp_code_length;
   logic [chtb_pkg::STATUS_W-1:0] rsp_status;

   canonical_huffman_table_builder_top DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_length_index (req_length_index),
      .req_length_count (req_length_count),
      .req_symbol       (req_symbol),
      .rsp_strobe       (rsp_strobe),
      .rsp_code_bits    (rsp_code_bits),
      .rsp_code_length  (rsp_code_length),
      .rsp_status       (rsp_status)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [chtb_pkg::COUNT_W-1:0]  counts_by_len [1:chtb_pkg::MAX_CODE_LENGTH_DEF];
   logic [chtb_pkg::CODE_W-1:0]   table_code [chtb_pkg::MAX_SYMBOLS_DEF];
   logic [chtb_pkg::LEN_W-1:0]    table_len [chtb_pkg::MAX_SYMBOLS_DEF];
   logic [chtb_pkg::LEN_W-1:0]    walk_len;
   logic [chtb_pkg::WALK_W-1:0]   walk_code;
   logic [chtb_pkg::COUNT_W-1:0]  walk_left;
   logic                          walk_begun;

   table_item_type  pending_items [$];
   code_result_type expected_codes [$];
   table_item_type  cur_item;
   logic [chtb_pkg::SYMBOL_W-1:0] placed_syms [$];

   int sent_n = 0;
   int checked_n = 0;
   int fail_count = 0;
   int gap_left = 0;
   int steady_left = 0;
   int idle_cycles = 0;
   int action_tally [4] = '{default: 0};
   int extra_seen = 0;
   int late_seen = 0;
   int long_codes = 0;

   function automatic void restart_table();
      counts_by_len = '{default: '0};
      table_len     = '{default: '0};
      walk_len      = chtb_pkg::LEN_W'(1);
      walk_code     = '0;
      walk_left     = '0;
      walk_begun    = 1'b0;
   endfunction

   function automatic code_result_type table_step(input table_item_type it);
      code_result_type r;
      logic [chtb_pkg::WALK_W-1:0] mask;
      r = '0;
      case (it.action)
         chtb_pkg::ACT_COUNT: begin
            if (walk_begun) begin
               r.status = chtb_pkg::ST_LATE_COUNT;
            end else if (it.length_index >= 1 &&
                         it.length_index <= chtb_pkg::MAX_CODE_LENGTH_DEF) begin
               counts_by_len[it.length_index] = it.length_count;
            end
         end
         chtb_pkg::ACT_SYMBOL: begin
            if (!walk_begun) begin
               walk_begun = 1'b1;
               walk_len   = chtb_pkg::LEN_W'(1);
               walk_code  = '0;
               walk_left  = counts_by_len[1];
            end
            while (walk_left == 0 && walk_len < chtb_pkg::MAX_CODE_LENGTH_DEF) begin
               walk_code = walk_code << 1;
               walk_len  = walk_len + 1'b1;
               walk_left = counts_by_len[walk_len];
            end
            if (walk_left == 0) begin
               r.status = chtb_pkg::ST_EXTRA_SYM;
            end else begin
               mask          = (chtb_pkg::WALK_W'(1) << walk_len) - 1'b1;
               r.code_bits   = chtb_pkg::CODE_W'(walk_code & mask);
               r.code_length = walk_len;
               walk_code     = walk_code + 1'b1;
               walk_left     = walk_left - 1'b1;
               table_code[it.symbol] = r.code_bits;
               table_len[it.symbol]  = walk_len;
            end
         end
         chtb_pkg::ACT_LOOKUP: begin
            if (table_len[it.symbol] != 0) begin
               r.code_bits   = table_code[it.symbol];
               r.code_length = table_len[it.symbol];
            end
         end
         default: begin
            restart_table();
         end
      endcase
      return r;
   endfunction

   task automatic queue_item(input logic [chtb_pkg::ACTION_W-1:0] act, input int idx,
                             input int cnt, input int sym, input bit drain);
      table_item_type it;
      it.action       = act;
      it.length_index = chtb_pkg::LIDX_W'(idx);
      it.length_count = chtb_pkg::COUNT_W'(cnt);
      it.symbol       = chtb_pkg::SYMBOL_W'(sym);
      it.drain_first  = drain;
      pending_items.push_back(it);
   endtask

   task automatic queue_random_table(input bit drain);
      int cnts [1:16];
      int max_len, avail, total, offset, l, n;
      bit first;
      cnts  = '{default: 0};
      first = drain;
      if ($urandom_range(0, 9) != 0) begin
         queue_item(chtb_pkg::ACT_CLEAR, $urandom_range(0, 31), $urandom_range(0, 255),
                    $urandom_range(0, 255), first);
         first = 1'b0;
      end
      placed_syms.delete();
      max_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      avail = 1;
      for (int k = 1; k <= max_len; k++) begin
         avail = (avail > 1000) ? avail : avail * 2;
         cnts[k] = $urandom_range(0, (avail < 4) ? avail : 4);
         avail -= cnts[k];
      end
      if ($urandom_range(0, 7) == 0)
         cnts[$urandom_range(1, max_len)] =
            $urandom_range(0, ($urandom_range(0, 3) == 0) ? 255 : 20);
      offset = $urandom_range(0, 15);
      total = 0;
      for (int k = 0; k < 16; k++) begin
         l = (k + offset) % 16 + 1;
         total += cnts[l];
         if (cnts[l] != 0 || $urandom_range(0, 3) == 0) begin
            queue_item(chtb_pkg::ACT_COUNT, l, cnts[l], $urandom_range(0, 255), first);
            first = 1'b0;
         end
         if ($urandom_range(0, 30) == 0)
            queue_item(chtb_pkg::ACT_COUNT,
                       ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31),
                       $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
      end
      n = total + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      for (int k = 0; k < n; k++) begin
         placed_syms.push_back(chtb_pkg::SYMBOL_W'($urandom_range(0, 255)));
         queue_item(chtb_pkg::ACT_SYMBOL, $urandom_range(0, 31), $urandom_range(0, 255),
                    placed_syms[$], first);
         first = 1'b0;
      end
      if ($urandom_range(0, 5) == 0)
         queue_item(chtb_pkg::ACT_COUNT, $urandom_range(1, 16), $urandom_range(0, 255),
                    $urandom_range(0, 255), 1'b0);
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         if (placed_syms.size() != 0 && $urandom_range(0, 3) != 0)
            queue_item(chtb_pkg::ACT_LOOKUP, $urandom_range(0, 31), $urandom_range(0, 255),
                       placed_syms[$urandom_range(0, placed_syms.size() - 1)], 1'b0);
         else
            queue_item(chtb_pkg::ACT_LOOKUP, $urandom_range(0, 31), $urandom_range(0, 255),
                       $urandom_range(0, 255), 1'b0);
      end
   endtask

   // driver
   always @(posedge clock) begin
      logic next_start;
      code_result_type r;
      int pick;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            r = table_step(cur_item);
            expected_codes.push_back(r);
            sent_n++;
            action_tally[cur_item.action]++;
            if (r.status == chtb_pkg::ST_EXTRA_SYM) extra_seen++;
            if (r.status == chtb_pkg::ST_LATE_COUNT) late_seen++;
            if (cur_item.action == chtb_pkg::ACT_SYMBOL &&
                r.code_length == chtb_pkg::MAX_CODE_LENGTH_DEF)
               long_codes++;
            next_start = 1'b0;
            if (steady_left > 0) begin
               steady_left--;
               gap_left = 0;
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 5)
                  steady_left = $urandom_range(20, 60);
               if (pick < 50)
                  gap_left = 0;
               else if (pick < 85)
                  gap_left = $urandom_range(1, 3);
               else if (pick < 97)
                  gap_left = $urandom_range(4, 10);
               else
                  gap_left = $urandom_range(20, 40);
            end
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               if (!busy) gap_left--;
            end else if (pending_items.size() != 0 &&
                         (!pending_items[0].drain_first || sent_n == checked_n)) begin
               cur_item = pending_items.pop_front();
               req_action       <= cur_item.action;
               req_length_index <= cur_item.length_index;
               req_length_count <= cur_item.length_count;
               req_symbol       <= cur_item.symbol;
               next_start = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   // monitor
   always @(posedge clock) begin
      code_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_codes.size() == 0) begin
            $display("%0t: result with none expected: code %h length %0d status %0d",
                     $time, rsp_code_bits, rsp_code_length, rsp_status);
            fail_count++;
         end else begin
            want = expected_codes.pop_front();
            checked_n <= checked_n + 1;
            if (rsp_code_bits !== want.code_bits) begin
               $display("%0t: code_bits expected %h actual %h", $time, want.code_bits,
                        rsp_code_bits);
               fail_count++;
            end
            if (rsp_code_length !== want.code_length) begin
               $display("%0t: code_length expected %0d actual %0d", $time, want.code_length,
                        rsp_code_length);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("canonical_huffman_table_builder_top_tb failed");
         $finish;
      end
   end

   initial begin
      restart_table();

      queue_item(chtb_pkg::ACT_LOOKUP, 0, 0, 0, 1'b0);
      queue_item(chtb_pkg::ACT_COUNT, 0, 255, 0, 1'b0);
      queue_item(chtb_pkg::ACT_COUNT, 31, 255, 255, 1'b0);
      queue_item(chtb_pkg::ACT_COUNT, 17, 7, 0, 1'b0);
      queue_item(chtb_pkg::ACT_SYMBOL, 0, 0, 9, 1'b0);
      queue_item(chtb_pkg::ACT_COUNT, 1, 1, 0, 1'b0);
      queue_item(chtb_pkg::ACT_CLEAR, 0, 0, 0, 1'b0);
      queue_item(chtb_pkg::ACT_COUNT, 1, 3, 0, 1'b0);
      queue_item(chtb_pkg::ACT_COUNT, 16, 1, 0, 1'b0);
      queue_item(chtb_pkg::ACT_SYMBOL, 0, 0, 0, 1'b0);
      queue_item(chtb_pkg::ACT_SYMBOL, 0, 0, 255, 1'b0);
      queue_item(chtb_pkg::ACT_SYMBOL, 0, 0, 128, 1'b0);
      queue_item(chtb_pkg::ACT_SYMBOL, 0, 0, 127, 1'b0);
      queue_item(chtb_pkg::ACT_SYMBOL, 0, 0, 1, 1'b0);
      queue_item(chtb_pkg::ACT_COUNT, 2, 1, 0, 1'b0);
      queue_item(chtb_pkg::ACT_LOOKUP, 0, 0, 255, 1'b0);
      queue_item(chtb_pkg::ACT_LOOKUP, 0, 0, 127, 1'b0);
      queue_item(chtb_pkg::ACT_LOOKUP, 0, 0, 0, 1'b0);
      queue_item(chtb_pkg::ACT_LOOKUP, 0, 0, 5, 1'b0);
      queue_item(chtb_pkg::ACT_CLEAR, 31, 255, 255, 1'b0);
      queue_item(chtb_pkg::ACT_LOOKUP, 0, 0, 127, 1'b0);
      queue_item(chtb_pkg::ACT_COUNT, 16, 255, 0, 1'b0);
      queue_item(chtb_pkg::ACT_SYMBOL, 0, 0, 7, 1'b0);
      queue_item(chtb_pkg::ACT_LOOKUP, 0, 0, 7, 1'b0);

      queue_random_table(1'b1);
      while (pending_items.size() < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            queue_item(chtb_pkg::ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                       $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
         else
            queue_random_table($urandom_range(0, 7) == 0);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_items.size() != 0 || start || sent_n != checked_n);
      repeat (25) @(posedge clock);
      if (expected_codes.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_codes.size());
         fail_count++;
      end

      $display("Checked %0d items: %0d count, %0d symbol, %0d lookup, %0d clear.",
               sent_n, action_tally[chtb_pkg::ACT_COUNT], action_tally[chtb_pkg::ACT_SYMBOL],
               action_tally[chtb_pkg::ACT_LOOKUP], action_tally[chtb_pkg::ACT_CLEAR]);
      $display("Seen %0d ignored symbols, %0d late counts, %0d codes of full length.",
               extra_seen, late_seen, long_codes);
      if (fail_count == 0)
         $display("canonical_huffman_table_builder_top_tb passed");
      else
         $display("canonical_huffman_table_builder_top_tb failed");
      $finish;
   end

endmodule
